[hw/rtl/rua_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types for the resource unit allocator.
// No dependencies.
package rua_pkg;

    localparam int NUM_PROCS  = 5;
    localparam int NUM_RES    = 5;
    localparam int HOLD_LIMIT = 30;

    // Field widths of the ports
    localparam int PROC_W     = 3;
    localparam int RES_W      = 3;
    localparam int UNITS_W    = 8;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Internal index and counter widths
    localparam int PROC_IW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int RES_IW   = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int CNT_W    = $clog2(NUM_PROCS + 1);
    localparam int HOLD_W   = $clog2(HOLD_LIMIT + 1);
    localparam int CELLS    = NUM_PROCS * NUM_RES;
    localparam int CELL_AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int QSUM_W   = $clog2(CELLS + 1);

    localparam logic [PROC_W-1:0]  PROCS_RST = 3'd5;
    localparam logic [RES_W-1:0]   RES_RST   = 3'd5;
    localparam logic [UNITS_W-1:0] UNITS_RST = 8'd1;
    localparam logic [UNITS_W-1:0] UNITS_MAX = 8'hFF;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_GRANTED  = 3'd0,
        OUT_BLOCKED  = 3'd1,
        OUT_RELEASED = 3'd2,
        OUT_HANDED   = 3'd3,
        OUT_BAD_PROC = 3'd4,
        OUT_BAD_RES  = 3'd5,
        OUT_NOT_HELD = 3'd6
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROCS      = 3'd0,
        CFG_RESOURCES  = 3'd1,
        CFG_UNITS0     = 3'd2,
        CFG_UNITS_LAST = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        REQ_ACQUIRE = 1'b0,
        REQ_RELEASE = 1'b1
    } req_t;

    typedef struct packed {
        outcome_t          outcome;
        logic              waiter_valid;
        logic [PROC_W-1:0] waiter_id;
        logic              hold_lost;
    } result_t;

    // Flat cell address of (process, resource) in the hold count memory
    function automatic logic [CELL_AW-1:0] cell_addr(logic [PROC_IW-1:0] p,
                                                     logic [RES_IW-1:0] r);
        return CELL_AW'(int'(p) * NUM_RES + int'(r));
    endfunction

    // Flat address of (resource, slot) in the wait queue memory
    function automatic logic [CELL_AW-1:0] queue_addr(logic [RES_IW-1:0] r,
                                                      logic [PROC_IW-1:0] s);
        return CELL_AW'(int'(r) * NUM_PROCS + int'(s));
    endfunction

endpackage

[hw/rtl/resource_unit_allocator_unit.sv]
`timescale 1ns / 1ps
// Resource unit allocator top level: counting semaphores with FIFO wait queues.
// Depends on rua_pkg and rua_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: req_type, process_id,
//   resource_id. Output channel (out_valid/out_ready) returns one result item
//   per input item: outcome, waiter_valid, waiter_id, units_free, hold_lost.
//   Configuration: cfg_we/cfg_index/cfg_data, written by the user only while
//   the block is idle; the block itself does not enforce it. An item passes
//   through READ, EVAL and DONE, with WEVAL after EVAL when a released unit
//   is handed to a waiter. One item is in work at a time, so the block takes
//   no new item until it is back in IDLE; the pace is set by the hold count
//   memory read-modify-write (registered read) and the second one for a waiter.
//   Reset: range registers at 5, one free unit per resource, no holdings, no
//   waiters; hold count cells read as zero until first written, so no clearing
//   pass is needed.
//   Stall: the result register holds while out_ready is low; the block takes
//   a new item meanwhile and waits at its final step until the register frees.
module resource_unit_allocator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rua_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rua_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [rua_pkg::PROC_W-1:0]        process_id,
    input  logic [rua_pkg::RES_W-1:0]         resource_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rua_pkg::OUTCOME_W-1:0]     outcome,
    output logic                              waiter_valid,
    output logic [rua_pkg::PROC_W-1:0]        waiter_id,
    output logic [rua_pkg::UNITS_W-1:0]       units_free,
    output logic                              hold_lost
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_WEVAL = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [rua_pkg::PROC_W-1:0]  procs_lim_reg, procs_lim_next;
    logic [rua_pkg::RES_W-1:0]   res_lim_reg, res_lim_next;
    logic [rua_pkg::UNITS_W-1:0] free_reg [rua_pkg::NUM_RES];
    logic [rua_pkg::UNITS_W-1:0] free_next [rua_pkg::NUM_RES];
    logic [rua_pkg::NUM_PROCS-1:0] blocked_reg, blocked_next;
    logic [rua_pkg::PROC_IW-1:0] head_reg [rua_pkg::NUM_RES];
    logic [rua_pkg::PROC_IW-1:0] head_next [rua_pkg::NUM_RES];
    logic [rua_pkg::CNT_W-1:0]   count_reg [rua_pkg::NUM_RES];
    logic [rua_pkg::CNT_W-1:0]   count_next [rua_pkg::NUM_RES];
    logic [rua_pkg::HOLD_W-1:0]  total_reg [rua_pkg::NUM_PROCS];
    logic [rua_pkg::HOLD_W-1:0]  total_next [rua_pkg::NUM_PROCS];
    logic [rua_pkg::CELLS-1:0]   held_vld_reg, held_vld_next;
    logic                        held_rvld_reg, held_rvld_next;

    logic                        type_reg, type_next;
    logic [rua_pkg::PROC_W-1:0]  pid_reg, pid_next;
    logic [rua_pkg::RES_W-1:0]   rid_reg, rid_next;
    logic [rua_pkg::PROC_W-1:0]  w_reg, w_next;
    rua_pkg::result_t            pend_reg, pend_next;
    logic                        out_valid_reg, out_valid_next;
    rua_pkg::result_t            out_res_reg, out_res_next;
    logic [rua_pkg::UNITS_W-1:0] out_free_reg, out_free_next;

    // Memory ports
    logic                        held_we;
    logic [rua_pkg::CELL_AW-1:0] held_waddr, held_raddr;
    logic [rua_pkg::HOLD_W-1:0]  held_wdata, held_rdata, held_cur;
    logic                        fifo_we;
    logic [rua_pkg::CELL_AW-1:0] fifo_waddr, fifo_raddr;
    logic [rua_pkg::PROC_W-1:0]  fifo_rdata;

    // Decoded item
    logic                        p_ok, r_ok, w_ok, wr_ok;
    logic [rua_pkg::PROC_IW-1:0] p_sel, w_sel, wr_sel, t_sel;
    logic [rua_pkg::RES_IW-1:0]  r_sel;
    logic [rua_pkg::UNITS_W-1:0] free_cur, free_up;
    logic [rua_pkg::PROC_IW-1:0] head_cur, head_inc, tail_slot;
    logic [rua_pkg::CNT_W-1:0]   count_cur;
    logic [rua_pkg::CNT_W:0]     tail_sum;
    logic                        total_full;
    logic [rua_pkg::CFG_IDX_W-1:0] cfg_unit;
    logic [rua_pkg::QSUM_W-1:0]  wait_total;

    rua_ram #(
        .WIDTH (rua_pkg::HOLD_W),
        .DEPTH (rua_pkg::CELLS)
    ) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (held_waddr),
        .wdata (held_wdata),
        .raddr (held_raddr),
        .rdata (held_rdata)
    );

    rua_ram #(
        .WIDTH (rua_pkg::PROC_W),
        .DEPTH (rua_pkg::CELLS)
    ) u_wait_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (pid_reg),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    assign p_ok   = (pid_reg < procs_lim_reg) && (int'(pid_reg) < rua_pkg::NUM_PROCS);
    assign r_ok   = (rid_reg < res_lim_reg) && (int'(rid_reg) < rua_pkg::NUM_RES);
    assign p_sel  = p_ok ? rua_pkg::PROC_IW'(pid_reg) : '0;
    assign r_sel  = r_ok ? rua_pkg::RES_IW'(rid_reg) : '0;
    assign w_ok   = int'(fifo_rdata) < rua_pkg::NUM_PROCS;
    assign w_sel  = w_ok ? rua_pkg::PROC_IW'(fifo_rdata) : '0;
    assign wr_ok  = int'(w_reg) < rua_pkg::NUM_PROCS;
    assign wr_sel = wr_ok ? rua_pkg::PROC_IW'(w_reg) : '0;
    assign t_sel  = (state_reg == ST_WEVAL) ? wr_sel : p_sel;

    // never-written hold count cells read as zero
    assign held_cur   = held_rvld_reg ? held_rdata : '0;

    assign free_cur   = free_reg[r_sel];
    assign free_up    = (free_cur != rua_pkg::UNITS_MAX) ? free_cur + 1'b1 : free_cur;
    assign head_cur   = head_reg[r_sel];
    assign count_cur  = count_reg[r_sel];
    assign head_inc   = (head_cur == rua_pkg::PROC_IW'(rua_pkg::NUM_PROCS - 1)) ?
                        '0 : head_cur + 1'b1;
    assign tail_sum   = (rua_pkg::CNT_W + 1)'(head_cur) + (rua_pkg::CNT_W + 1)'(count_cur);
    assign tail_slot  = (int'(tail_sum) >= rua_pkg::NUM_PROCS) ?
                        rua_pkg::PROC_IW'(tail_sum - (rua_pkg::CNT_W + 1)'(rua_pkg::NUM_PROCS)) :
                        rua_pkg::PROC_IW'(tail_sum);
    assign total_full = total_reg[t_sel] >= rua_pkg::HOLD_W'(rua_pkg::HOLD_LIMIT);
    assign cfg_unit   = cfg_index - rua_pkg::CFG_UNITS0;

    assign held_raddr = (state_reg == ST_EVAL) ? rua_pkg::cell_addr(w_sel, r_sel) :
                        rua_pkg::cell_addr(p_sel, r_sel);
    assign fifo_raddr = rua_pkg::queue_addr(r_sel, head_cur);
    assign fifo_waddr = rua_pkg::queue_addr(r_sel, tail_slot);

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        procs_lim_next = procs_lim_reg;
        res_lim_next   = res_lim_reg;
        free_next      = free_reg;
        blocked_next   = blocked_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        type_next      = type_reg;
        pid_next       = pid_reg;
        rid_next       = rid_reg;
        w_next         = w_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_free_next  = out_free_reg;
        held_vld_next  = held_vld_reg;
        held_rvld_next = held_vld_reg[held_raddr];
        held_we        = 1'b0;
        held_waddr     = rua_pkg::cell_addr(p_sel, r_sel);
        held_wdata     = held_cur;
        fifo_we        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            priority if (cfg_index == rua_pkg::CFG_PROCS)
            begin
                procs_lim_next = rua_pkg::PROC_W'(cfg_data);
            end
            else if (cfg_index == rua_pkg::CFG_RESOURCES)
            begin
                res_lim_next = rua_pkg::RES_W'(cfg_data);
            end
            else if (cfg_index >= rua_pkg::CFG_UNITS0 && cfg_index <= rua_pkg::CFG_UNITS_LAST
                     && int'(cfg_unit) < rua_pkg::NUM_RES)
            begin
                free_next[rua_pkg::RES_IW'(cfg_unit)] = rua_pkg::UNITS_W'(cfg_data);
            end
            else
            begin
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    type_next  = req_type;
                    pid_next   = process_id;
                    rid_next   = resource_id;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                pend_next.outcome      = rua_pkg::OUT_GRANTED;
                pend_next.waiter_valid = 1'b0;
                pend_next.waiter_id    = '0;
                pend_next.hold_lost    = 1'b0;
                state_next             = ST_DONE;
                priority if (!p_ok || blocked_reg[p_sel])
                begin
                    pend_next.outcome = rua_pkg::OUT_BAD_PROC;
                end
                else if (!r_ok)
                begin
                    pend_next.outcome = rua_pkg::OUT_BAD_RES;
                end
                else if (type_reg == rua_pkg::REQ_ACQUIRE)
                begin
                    if (free_cur == '0)
                    begin
                        pend_next.outcome   = rua_pkg::OUT_BLOCKED;
                        blocked_next[p_sel] = 1'b1;
                        if (int'(count_cur) < rua_pkg::NUM_PROCS)
                        begin
                            fifo_we           = 1'b1;
                            count_next[r_sel] = count_cur + 1'b1;
                        end
                    end
                    else
                    begin
                        free_next[r_sel] = free_cur - 1'b1;
                        if (total_full)
                        begin
                            pend_next.hold_lost = 1'b1;
                        end
                        else
                        begin
                            total_next[p_sel] = total_reg[p_sel] + 1'b1;
                            held_we           = 1'b1;
                            held_wdata        = held_cur + 1'b1;
                        end
                    end
                end
                else
                begin
                    if (held_cur == '0)
                    begin
                        pend_next.outcome = rua_pkg::OUT_NOT_HELD;
                    end
                    else
                    begin
                        held_we           = 1'b1;
                        held_wdata        = held_cur - 1'b1;
                        total_next[p_sel] = total_reg[p_sel] - 1'b1;
                        if (count_cur != '0)
                        begin
                            head_next[r_sel]       = head_inc;
                            count_next[r_sel]      = count_cur - 1'b1;
                            blocked_next[w_sel]    = 1'b0;
                            free_next[r_sel]       = free_up - 1'b1;
                            w_next                 = fifo_rdata;
                            pend_next.outcome      = rua_pkg::OUT_HANDED;
                            pend_next.waiter_valid = 1'b1;
                            pend_next.waiter_id    = fifo_rdata;
                            state_next             = ST_WEVAL;
                        end
                        else
                        begin
                            free_next[r_sel]  = free_up;
                            pend_next.outcome = rua_pkg::OUT_RELEASED;
                        end
                    end
                end
            end

            ST_WEVAL:
            begin
                // unit goes to the oldest waiter
                if (total_full)
                begin
                    pend_next.hold_lost = 1'b1;
                end
                else
                begin
                    total_next[wr_sel] = total_reg[wr_sel] + 1'b1;
                    held_we            = 1'b1;
                    held_waddr         = rua_pkg::cell_addr(wr_sel, r_sel);
                    held_wdata         = held_cur + 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = pend_reg;
                    out_free_next  = r_ok ? free_reg[r_sel] : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (held_we)
        begin
            held_vld_next[held_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            procs_lim_reg <= rua_pkg::PROCS_RST;
            res_lim_reg   <= rua_pkg::RES_RST;
            blocked_reg   <= '0;
            out_valid_reg <= 1'b0;
            held_vld_reg  <= '0;
            held_rvld_reg <= 1'b0;
            for (int i = 0; i < rua_pkg::NUM_RES; i++)
            begin
                free_reg[i]  <= rua_pkg::UNITS_RST;
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            for (int i = 0; i < rua_pkg::NUM_PROCS; i++)
            begin
                total_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            procs_lim_reg <= procs_lim_next;
            res_lim_reg   <= res_lim_next;
            blocked_reg   <= blocked_next;
            out_valid_reg <= out_valid_next;
            held_vld_reg  <= held_vld_next;
            held_rvld_reg <= held_rvld_next;
            free_reg      <= free_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        pid_reg      <= pid_next;
        rid_reg      <= rid_next;
        w_reg        <= w_next;
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
        out_free_reg <= out_free_next;
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = out_res_reg.outcome;
    assign waiter_valid = out_res_reg.waiter_valid;
    assign waiter_id    = out_res_reg.waiter_id;
    assign units_free   = out_free_reg;
    assign hold_lost    = out_res_reg.hold_lost;

    always_comb
    begin
        wait_total = '0;
        for (int i = 0; i < rua_pkg::NUM_RES; i++)
        begin
            wait_total = wait_total + rua_pkg::QSUM_W'(count_reg[i]);
        end
    end

    // the number of blocked processes equals the number of queued waiters
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(blocked_reg) == int'(wait_total))
        else $error("blocked processes and queued waiters disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (waiter_valid == (outcome == rua_pkg::OUT_HANDED)))
        else $error("waiter flag does not match outcome");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hold_lost) |->
        (outcome == rua_pkg::OUT_GRANTED || outcome == rua_pkg::OUT_HANDED))
        else $error("hold lost without a grant");

endmodule

[hw/rtl/rua_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
